// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point plotter core.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/zbpp_pkg.sv
// ---------------------------------------------------------------------------
// Point plotter package
// Types, codes and the shade ramp shared by the plotter modules.
// ---------------------------------------------------------------------------
`default_nettype none
package zbpp_pkg;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_PLOT  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CFG_FOCAL_X = 3'd0,
      CFG_FOCAL_Y = 3'd1,
      CFG_CENTER_X = 3'd2,
      CFG_CENTER_Y = 3'd3,
      CFG_ACTIVE_COLS = 3'd4,
      CFG_ACTIVE_ROWS = 3'd5
   } cfg_idx_type;

   typedef enum logic [2:0] {
      FE_IDLE,
      FE_MUL,
      FE_SUM,
      FE_DIV,
      FE_DONE
   } fe_state_type;

   typedef enum logic [2:0] {
      BE_IDLE,
      BE_CLEAR,
      BE_RD,
      BE_WAIT,
      BE_DECIDE,
      BE_OUT
   } be_state_type;

   localparam logic [7:0]  BLANK_CHAR = 8'd32;
   localparam logic [31:0] MAX_DEPTH  = 32'hFFFF_FFFF;

   function automatic logic [7:0] ramp_char(input logic [3:0] idx);
      logic [7:0] c;
      unique case (idx)
         4'd0: c = 8'h2E;
         4'd1: c = 8'h2C;
         4'd2: c = 8'h2D;
         4'd3: c = 8'h7E;
         4'd4: c = 8'h3A;
         4'd5: c = 8'h3B;
         4'd6: c = 8'h3D;
         4'd7: c = 8'h21;
         4'd8: c = 8'h2A;
         4'd9: c = 8'h23;
         4'd10: c = 8'h24;
         default: c = 8'h40;
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/zbpp_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module zbpp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/core/zbpp_div.sv
// ---------------------------------------------------------------------------
// Restoring divider
// Unsigned 64 by 48 bit division, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module zbpp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [47:0] den,
   output logic             busy,
   output logic [63:0]      quo
);
   logic [63:0] q_ff, q_in;
   logic [48:0] r_ff, r_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [48:0] trial;

   always_comb begin
      q_in   = q_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      trial  = {r_ff[47:0], q_ff[63]};
      if (start) begin
         q_in   = num;
         r_in   = '0;
         cnt_in = 7'd64;
      end else if (cnt_ff != 7'd0) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign busy = (cnt_ff != 7'd0);
   assign quo  = q_ff;
endmodule
`default_nettype wire

// File: rtl/core/zbpp_front.sv
// ---------------------------------------------------------------------------
// Front end
// Accept words, project plot points and hand commands to the queue.
// ---------------------------------------------------------------------------
`default_nettype none
module zbpp_front #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire zbpp_pkg::op_type in_op,
   input  wire logic [31:0] in_x,
   input  wire logic [31:0] in_y,
   input  wire logic [31:0] in_z,
   input  wire logic [15:0] in_illum,
   input  wire logic [6:0]  in_rcol,
   input  wire logic [5:0]  in_rrow,
   input  wire logic [31:0] focal_x,
   input  wire logic [31:0] focal_y,
   input  wire logic [31:0] center_x,
   input  wire logic [31:0] center_y,
   input  wire logic [7:0]  active_cols,
   input  wire logic [6:0]  active_rows,
   output logic             cmd_valid,
   input  wire logic        cmd_ready,
   output zbpp_pkg::op_type cmd_op,
   output logic             cmd_hit,
   output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] cmd_addr,
   output logic [31:0]      cmd_z,
   output logic [7:0]       cmd_char
);
   import zbpp_pkg::*;
   localparam int AW = $clog2(MAX_ROWS*MAX_COLS);
   localparam int CW = $clog2(MAX_COLS) + 1;
   localparam int RW = $clog2(MAX_ROWS) + 1;

   fe_state_type st_ff, st_in;
   op_type  op_ff;
   logic [31:0] x_ff, y_ff, z_ff, fx_ff, fy_ff, cx_ff, cy_ff;
   logic [15:0] il_ff;
   logic [6:0]  rc_ff;
   logic [5:0]  rr_ff;
   logic        axis_ff, axis_in;
   logic [63:0] a_ff, b_ff;
   logic [63:0] m_ff, m_in;
   logic        neg_ff, neg_in;
   logic [31:0] col_ff, col_in;
   logic        ok_ff, ok_in;
   logic [63:0] a_prod, b_prod;
   logic [31:0] p_sel, c_sel, f_sel, p_mag, c_mag;
   logic        sa, sb;
   logic        div_start, div_busy;
   logic [63:0] div_num, div_quo;
   logic [47:0] div_den;
   logic [31:0] lim;
   logic [7:0]  cols_eff;
   logic [6:0]  rows_eff;
   logic        coord_ok;
   logic [4:0]  shade_idx;
   logic [19:0] shade_mul;

   zbpp_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .num (div_num), .den (div_den), .busy (div_busy), .quo (div_quo)
   );

   // multiplier operand selection per axis
   assign p_sel = axis_ff ? y_ff : x_ff;
   assign c_sel = axis_ff ? cy_ff : cx_ff;
   assign f_sel = axis_ff ? fy_ff : fx_ff;
   assign p_mag = p_sel[31] ? (~p_sel + 32'd1) : p_sel;
   assign c_mag = c_sel[31] ? (~c_sel + 32'd1) : c_sel;
   assign a_prod = {32'd0, f_sel} * {32'd0, p_mag};
   assign b_prod = {32'd0, c_mag} * {32'd0, z_ff};

   always_ff @(posedge clock) begin
      a_ff <= a_prod;
      b_ff <= b_prod;
   end

   assign sa = p_sel[31] && (a_ff != 64'd0);
   assign sb = c_sel[31] && (b_ff != 64'd0);
   assign div_den = {z_ff[31:0], 16'd0};

   always_comb begin
      if (sa == sb) begin
         m_in = a_ff + b_ff;
         neg_in = sa;
      end else if (a_ff >= b_ff) begin
         m_in = a_ff - b_ff;
         neg_in = sa;
      end else begin
         m_in = b_ff - a_ff;
         neg_in = sb;
      end
   end

   assign div_num = m_ff + {17'd0, z_ff[31:0], 15'd0};

   assign cols_eff = (active_cols < 8'(MAX_COLS > 255 ? 255 : MAX_COLS)) ? active_cols
                    : 8'(MAX_COLS > 255 ? 255 : MAX_COLS);
   assign rows_eff = (active_rows < 7'(MAX_ROWS > 127 ? 127 : MAX_ROWS)) ? active_rows
                    : 7'(MAX_ROWS > 127 ? 127 : MAX_ROWS);
   assign lim = axis_ff ? {25'd0, rows_eff} : {24'd0, cols_eff};
   assign coord_ok = !(neg_ff && div_quo != 64'd0) && (div_quo < {32'd0, lim});

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         FE_IDLE: if (in_valid) begin
            st_in = (in_op == OP_PLOT && !in_z[31] && in_z != 32'd0) ? FE_MUL : FE_DONE;
         end
         FE_MUL:  st_in = FE_SUM;
         FE_SUM:  st_in = FE_DIV;
         FE_DIV:  if (!div_busy && !div_start) begin
            st_in = (axis_ff || !coord_ok) ? FE_DONE : FE_MUL;
         end
         FE_DONE: if (cmd_ready) st_in = FE_IDLE;
         default: st_in = FE_IDLE;
      endcase
   end

   // start divide the cycle after the sum lands
   logic go_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff <= 1'b0;
      end else begin
         go_ff <= (st_ff == FE_SUM);
      end
   end
   assign div_start = go_ff;

   always_comb begin
      axis_in = axis_ff;
      col_in  = col_ff;
      ok_in   = ok_ff;
      if (st_ff == FE_IDLE) begin
         axis_in = 1'b0;
         ok_in   = in_op == OP_PLOT && !in_z[31] && in_z != 32'd0;
      end else if (st_ff == FE_DIV && !div_busy && !div_start) begin
         ok_in = ok_ff && coord_ok;
         if (!axis_ff) begin
            col_in  = div_quo[31:0];
            axis_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= FE_IDLE;
      end else begin
         st_ff <= st_in;
      end
      axis_ff <= axis_in;
      col_ff  <= col_in;
      ok_ff   <= ok_in;
      m_ff    <= m_in;
      neg_ff  <= neg_in;
      if (st_ff == FE_IDLE && in_valid) begin
         op_ff <= in_op;
         x_ff  <= in_x;
         y_ff  <= in_y;
         z_ff  <= in_z;
         il_ff <= in_illum;
         rc_ff <= in_rcol;
         rr_ff <= in_rrow;
         fx_ff <= focal_x;
         fy_ff <= focal_y;
         cx_ff <= center_x;
         cy_ff <= center_y;
      end
   end

   // row register is the last divider result
   logic [31:0] row_ff;
   always_ff @(posedge clock) begin
      if (st_ff == FE_DIV && !div_busy && !div_start && axis_ff) begin
         row_ff <= div_quo[31:0];
      end
   end

   assign shade_mul = {4'd0, il_ff} * 20'd12;
   always_comb begin
      if (il_ff[15]) begin
         shade_idx = 5'd0;
      end else if (shade_mul[19:12] > 8'd11) begin
         shade_idx = 5'd11;
      end else begin
         shade_idx = shade_mul[16:12];
      end
   end

   assign in_ready  = (st_ff == FE_IDLE);
   assign cmd_valid = (st_ff == FE_DONE);
   assign cmd_op    = op_ff;
   assign cmd_hit   = (op_ff == OP_PLOT) ? ok_ff
                      : (op_ff == OP_READ) ? ({25'd0, rc_ff} < 32'(MAX_COLS)
                                              && {26'd0, rr_ff} < 32'(MAX_ROWS))
                      : 1'b0;
   assign cmd_addr  = (op_ff == OP_PLOT)
                      ? AW'(row_ff[RW-1:0] * MAX_COLS + col_ff[CW-1:0])
                      : AW'({26'd0, rr_ff} * MAX_COLS + {25'd0, rc_ff});
   assign cmd_z     = z_ff;
   assign cmd_char  = ramp_char(shade_idx[3:0]);
endmodule
`default_nettype wire

// File: rtl/core/zbpp_back.sv
// ---------------------------------------------------------------------------
// Back end
// Carry out clear, depth test and read against the two stores.
// ---------------------------------------------------------------------------
`default_nettype none
module zbpp_back #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        cmd_valid,
   output logic             cmd_ready,
   input  wire zbpp_pkg::op_type cmd_op,
   input  wire logic        cmd_hit,
   input  wire logic [$clog2(MAX_ROWS*MAX_COLS)-1:0] cmd_addr,
   input  wire logic [31:0] cmd_z,
   input  wire logic [7:0]  cmd_char,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic             out_written,
   output logic [7:0]       out_char,
   output logic [31:0]      out_depth,
   output logic             clearing
);
   import zbpp_pkg::*;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW = $clog2(DEPTH);

   be_state_type st_ff, st_in;
   logic [AW:0]  sweep_ff, sweep_in;
   logic         init_ff, init_in;
   op_type       op_ff;
   logic         hit_ff;
   logic [AW-1:0] addr_ff;
   logic [31:0]  z_ff;
   logic [7:0]   ch_ff;
   logic         wr_ff, wr_in;
   logic [7:0]   oc_ff, oc_in;
   logic [31:0]  od_ff, od_in;
   logic         we;
   logic [AW-1:0] wa;
   logic [7:0]   wch;
   logic [31:0]  wz;
   logic [7:0]   rd_ch;
   logic [31:0]  rd_z;

   zbpp_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_frame (
      .clock (clock), .wr_en (we), .wr_addr (wa), .wr_data (wch),
      .rd_addr (addr_ff), .rd_data (rd_ch)
   );
   zbpp_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_depth (
      .clock (clock), .wr_en (we), .wr_addr (wa), .wr_data (wz),
      .rd_addr (addr_ff), .rd_data (rd_z)
   );

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BE_IDLE: if (cmd_valid) begin
            priority case (1'b1)
               cmd_op == OP_CLEAR: st_in = BE_CLEAR;
               cmd_hit:            st_in = BE_RD;
               default:            st_in = BE_OUT;
            endcase
         end
         BE_CLEAR:  if (sweep_ff == (AW+1)'(DEPTH - 1)) begin
            st_in = init_ff ? BE_IDLE : BE_OUT;
         end
         BE_RD:     st_in = BE_WAIT;
         BE_WAIT:   st_in = BE_DECIDE;
         BE_DECIDE: st_in = BE_OUT;
         BE_OUT:    if (out_ready) st_in = BE_IDLE;
         default:   st_in = BE_IDLE;
      endcase
   end

   always_comb begin
      sweep_in = sweep_ff;
      init_in  = init_ff;
      if (st_ff == BE_CLEAR) begin
         sweep_in = sweep_ff + (AW+1)'(1);
         if (sweep_ff == (AW+1)'(DEPTH - 1)) init_in = 1'b0;
      end else begin
         sweep_in = '0;
      end
   end

   always_comb begin
      we  = 1'b0;
      wa  = addr_ff;
      wch = ch_ff;
      wz  = z_ff;
      if (st_ff == BE_CLEAR) begin
         we  = 1'b1;
         wa  = sweep_ff[AW-1:0];
         wch = BLANK_CHAR;
         wz  = MAX_DEPTH;
      end else if (st_ff == BE_DECIDE && op_ff == OP_PLOT && z_ff < rd_z) begin
         we = 1'b1;
      end
   end

   always_comb begin
      wr_in = wr_ff;
      oc_in = oc_ff;
      od_in = od_ff;
      if (st_ff == BE_IDLE) begin
         wr_in = 1'b0;
         oc_in = '0;
         od_in = '0;
      end else if (st_ff == BE_DECIDE) begin
         if (op_ff == OP_PLOT) begin
            wr_in = z_ff < rd_z;
         end else begin
            oc_in = rd_ch;
            od_in = rd_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= BE_CLEAR;
         init_ff <= 1'b1;
         sweep_ff <= '0;
      end else begin
         st_ff   <= st_in;
         init_ff <= init_in;
         sweep_ff <= sweep_in;
      end
      wr_ff <= wr_in;
      oc_ff <= oc_in;
      od_ff <= od_in;
      if (st_ff == BE_IDLE && cmd_valid) begin
         op_ff   <= cmd_op;
         hit_ff  <= cmd_hit;
         addr_ff <= cmd_addr;
         z_ff    <= cmd_z;
         ch_ff   <= cmd_char;
      end
   end

   assign cmd_ready   = (st_ff == BE_IDLE);
   assign out_valid   = (st_ff == BE_OUT);
   assign out_written = wr_ff && hit_ff;
   assign out_char    = oc_ff;
   assign out_depth   = od_ff;
   assign clearing    = init_ff;
endmodule
`default_nettype wire

// File: rtl/core/zbuffer_point_plotter_core.sv
// ---------------------------------------------------------------------------
// Depth-tested point plotter core
// Projects points into a character frame store guarded by a depth store.
// ---------------------------------------------------------------------------
// After reset the core sweeps both stores, one entry a cycle, over all
// MAX_ROWS*MAX_COLS entries (8192 at the defaults) before it takes a word.
// A plot word runs through the front end: two 32x32 multiplies per axis, a
// step to form the signed sum and a restoring divider, used once per axis,
// which dominates the cost of a plot. The back end then steps through take,
// read, wait, decide and emit for the read-modify-write of the stores. A
// clear word sweeps all MAX_ROWS*MAX_COLS entries. One word is in the front,
// one in the queue and one in the back at a time.
`default_nettype none
module zbuffer_point_plotter_core #(
   parameter int MAX_COLS = 128,
   parameter int MAX_ROWS = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // operation[1:0], point_x[33:2], point_y[65:34], point_z[97:66],
   // illumination[113:98], read_col[120:114], read_row[126:121]
   input  wire logic [127:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // written[0], pixel_char[8:1], pixel_depth[40:9]
   output logic [47:0]       rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import zbpp_pkg::*;
   localparam int AW = $clog2(MAX_ROWS*MAX_COLS);

   logic [31:0] fx_ff, fy_ff, cx_ff, cy_ff;
   logic [7:0]  ac_ff;
   logic [6:0]  ar_ff;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= 32'd65536;
         fy_ff <= 32'd65536;
         cx_ff <= '0;
         cy_ff <= '0;
         ac_ff <= 8'd128;
         ar_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (cfg_idx_type'(csr_index))
            CFG_FOCAL_X:     fx_ff <= csr_wdata;
            CFG_FOCAL_Y:     fy_ff <= csr_wdata;
            CFG_CENTER_X:    cx_ff <= csr_wdata;
            CFG_CENTER_Y:    cy_ff <= csr_wdata;
            CFG_ACTIVE_COLS: ac_ff <= csr_wdata[7:0];
            CFG_ACTIVE_ROWS: ar_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   logic        fe_ready, clearing;
   logic        q_valid_ff, q_valid_in;
   op_type      q_op_ff, cmd_op;
   logic        q_hit_ff, cmd_hit;
   logic [AW-1:0] q_addr_ff, cmd_addr;
   logic [31:0] q_z_ff, cmd_z;
   logic [7:0]  q_ch_ff, cmd_char;
   logic        cmd_valid, cmd_ready, be_ready;
   logic        out_written;
   logic [7:0]  out_char;
   logic [31:0] out_depth;

   // hold off input during the power-up sweep
   assign req_tready = fe_ready && !clearing;

   zbpp_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock (clock), .reset (reset),
      .in_valid (req_tvalid && !clearing), .in_ready (fe_ready),
      .in_op (op_type'(req_tdata[1:0])),
      .in_x (req_tdata[33:2]), .in_y (req_tdata[65:34]), .in_z (req_tdata[97:66]),
      .in_illum (req_tdata[113:98]), .in_rcol (req_tdata[120:114]),
      .in_rrow (req_tdata[126:121]),
      .focal_x (fx_ff), .focal_y (fy_ff), .center_x (cx_ff), .center_y (cy_ff),
      .active_cols (ac_ff), .active_rows (ar_ff),
      .cmd_valid (cmd_valid), .cmd_ready (cmd_ready),
      .cmd_op (cmd_op), .cmd_hit (cmd_hit), .cmd_addr (cmd_addr),
      .cmd_z (cmd_z), .cmd_char (cmd_char)
   );

   // one-entry command queue between front and back
   assign cmd_ready  = !q_valid_ff;
   assign q_valid_in = (cmd_valid && cmd_ready) ? 1'b1
                       : (q_valid_ff && be_ready) ? 1'b0 : q_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff <= 1'b0;
      end else begin
         q_valid_ff <= q_valid_in;
      end
      if (cmd_valid && cmd_ready) begin
         q_op_ff   <= cmd_op;
         q_hit_ff  <= cmd_hit;
         q_addr_ff <= cmd_addr;
         q_z_ff    <= cmd_z;
         q_ch_ff   <= cmd_char;
      end
   end

   zbpp_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_back (
      .clock (clock), .reset (reset),
      .cmd_valid (q_valid_ff), .cmd_ready (be_ready),
      .cmd_op (q_op_ff), .cmd_hit (q_hit_ff), .cmd_addr (q_addr_ff),
      .cmd_z (q_z_ff), .cmd_char (q_ch_ff),
      .out_valid (rsp_tvalid), .out_ready (rsp_tready),
      .out_written (out_written), .out_char (out_char), .out_depth (out_depth),
      .clearing (clearing)
   );

   assign rsp_tdata = {7'd0, out_depth, out_char, out_written};

`include "assert_macros.svh"
   `ASSERT_IMPL(a_no_accept_clr, clock, reset, clearing, !req_tready, "input taken during sweep")
   `ASSERT_IMPL(a_written_excl, clock, reset, rsp_tvalid && out_written,
      out_char == 8'd0 && out_depth == 32'd0, "written with read data")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result dropped while stalled")
endmodule
`default_nettype wire

// File: tb/zbuffer_point_plotter_core_test.sv
// ---------------------------------------------------------------------------
// Point plotter core testbench
// Drives clear, plot and read words into the plotter core: a directed table,
// then random words under several camera settings. Each result is checked
// against its table entry or a local model of the frame and depth stores.
// ---------------------------------------------------------------------------
`default_nettype none
module zbuffer_point_plotter_core_test;
   import zbpp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS       = 128;
   localparam int ROWS       = 64;
   localparam int STORE_SIZE = COLS * ROWS;
   // Quiet cycles after the last result before the registers are touched.
   localparam int SETTLE_CYCLES = 300;
   // Long enough for several plots to fill front, queue and back.
   localparam int HOLD_CYCLES   = 1200;

   // Result word as seen on the master side.
   typedef struct packed {
      logic        written;
      logic [7:0]  pixel_char;
      logic [31:0] pixel_depth;
   } pixel_result_type;

   // One row of the directed table.
   typedef struct {
      op_type           op;
      logic [31:0]      px;
      logic [31:0]      py;
      logic [31:0]      pz;
      logic [15:0]      illum;
      logic [6:0]       rcol;
      logic [5:0]       rrow;
      bit               typed;
      pixel_result_type res;
   } plot_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic [2:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   zbuffer_point_plotter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Model state: both stores and a copy of every register.
   logic [7:0]  char_mem  [STORE_SIZE];
   logic [31:0] depth_mem [STORE_SIZE];
   logic [31:0] cam_fx, cam_fy, cam_cx, cam_cy;
   logic [7:0]  act_cols;
   logic [6:0]  act_rows;
   logic [7:0]  ramp [12] = '{8'h2E, 8'h2C, 8'h2D, 8'h7E, 8'h3A, 8'h3B,
                              8'h3D, 8'h21, 8'h2A, 8'h23, 8'h24, 8'h40};

   pixel_result_type owed_pixels[$];
   int  fails = 0;
   bit  calm = 1'b0;          // when set, neither side idles
   int  hold_count = 0;       // bump to make the receiver hold off
   int  hold_seen = 0;
   int  hold_left = 0;

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s: got %h, want %h at %0t", what, got, want, $realtime);
      fails++;
   endtask

   function automatic void wipe_stores();
      for (int i = 0; i < STORE_SIZE; i++) begin
         char_mem[i]  = BLANK_CHAR;
         depth_mem[i] = MAX_DEPTH;
      end
   endfunction

   function automatic logic [63:0] magnitude(input logic [31:0] v);
      logic [31:0] n;
      n = -v;
      return v[31] ? {32'd0, n} : {32'd0, v};
   endfunction

   // Round f*p/z + c half away from zero; true when it lands in 0..lim-1.
   function automatic bit project_axis(input logic [31:0] f, p, c, z, lim,
                                       output logic [31:0] coord);
      logic [63:0] a, b, m, d, q;
      bit sa, sb, neg;
      a  = {32'd0, f} * magnitude(p);
      b  = magnitude(c) * {32'd0, z};
      sa = p[31] && a != 0;
      sb = c[31] && b != 0;
      d  = {32'd0, z} << 16;
      if (sa == sb) begin
         m = a + b;
         neg = sa;
      end else if (a >= b) begin
         m = a - b;
         neg = sa;
      end else begin
         m = b - a;
         neg = sb;
      end
      q = (m + d / 2) / d;
      coord = q[31:0];
      if (neg && q != 0) return 0;
      return q < {32'd0, lim};
   endfunction

   function automatic logic [7:0] shade_of(input logic [15:0] il);
      logic [31:0] idx;
      idx = il[15] ? 32'd0 : ({16'd0, il} * 12) >> 12;
      if (idx > 11) idx = 11;
      return ramp[idx];
   endfunction

   // Apply one word to the model stores and return the result it earns.
   function automatic pixel_result_type plot_model_step(input logic [1:0] op,
         input logic [31:0] px, py, pz, input logic [15:0] il,
         input logic [6:0] rc, input logic [5:0] rr);
      pixel_result_type r;
      logic [31:0] cl, rl, col, row;
      int adr;
      r = '0;
      cl = act_cols < COLS ? act_cols : COLS;
      rl = act_rows < ROWS ? act_rows : ROWS;
      case (op)
         OP_CLEAR: wipe_stores();
         OP_PLOT: begin
            if (pz != 0 && !pz[31] &&
                project_axis(cam_fx, px, cam_cx, pz, cl, col) &&
                project_axis(cam_fy, py, cam_cy, pz, rl, row)) begin
               adr = row * COLS + col;
               if (pz < depth_mem[adr]) begin
                  char_mem[adr]  = shade_of(il);
                  depth_mem[adr] = pz;
                  r.written = 1'b1;
               end
            end
         end
         OP_READ: begin
            adr = rr * COLS + rc;
            r.pixel_char  = char_mem[adr];
            r.pixel_depth = depth_mem[adr];
         end
         default: ;
      endcase
      return r;
   endfunction

   // Offer one word and hold it until accepted; predict at acceptance.
   task automatic send_word(input logic [1:0] op, input logic [31:0] px, py, pz,
                            input logic [15:0] il, input logic [6:0] rc,
                            input logic [5:0] rr, input bit typed,
                            input pixel_result_type typed_res);
      pixel_result_type r;
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, rr, rc, il, pz, py, px, op};
      do @(posedge clock); while (!req_tready);
      r = plot_model_step(op, px, py, pz, il, rc, rr);
      owed_pixels.push_back(typed ? typed_res : r);
      gap = (!calm && $urandom_range(0, 99) < 18) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (owed_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all six registers back to back; block must be idle.
   task automatic write_camera(input logic [31:0] fx, fy, cx, cy,
                               input logic [7:0] ac, input logic [6:0] ar);
      logic [31:0] vals [6];
      vals = '{fx, fy, cx, cy, {24'd0, ac}, {25'd0, ar}};
      for (int i = 0; i < 6; i++) begin
         csr_we    <= 1'b1;
         csr_index <= cfg_idx_type'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cam_fx = fx; cam_fy = fy; cam_cx = cx; cam_cy = cy;
      act_cols = ac; act_rows = ar;
   endtask

   // Random words: mostly aimed plots and reads, with some noise.
   task automatic random_words(input int count, input int pause_at,
                               input int hold_at);
      int sel, c, r;
      logic [1:0]  op;
      logic [31:0] px, py, pz;
      logic [15:0] il;
      logic [6:0]  rc;
      logic [5:0]  rr;
      for (int n = 0; n < count; n++) begin
         if (n == pause_at) drain();
         if (n == hold_at) hold_count <= hold_count + 1;
         sel = $urandom_range(0, 999);
         c = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 7) : $urandom_range(0, 127);
         r = ($urandom_range(0, 9) < 4) ? $urandom_range(0, 7) : $urandom_range(0, 63);
         pz = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 1 << 20)
                                         : $urandom_range(1, 32'h7FFF_FFFF);
         px = 32'((longint'(c) - 64) * longint'(pz) / 64);
         py = 32'((longint'(r) - 32) * longint'(pz) / 32);
         il = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 16'h1100));
         rc = 7'(c);
         rr = 6'(r);
         op = OP_PLOT;
         if (sel < 6) begin
            op = OP_CLEAR;
         end else if (sel < 560) begin
            op = OP_PLOT;
         end else if (sel < 700) begin
            // noise: a plot word with random point and read fields
            px = $urandom(); py = $urandom(); pz = $urandom();
            rc = 7'($urandom()); rr = 6'($urandom());
         end else if (sel < 960) begin
            op = OP_READ;
            if ($urandom_range(0, 1)) begin
               rc = 7'($urandom());
               rr = 6'($urandom());
            end
         end else begin
            op = OP_NONE;
            px = $urandom(); py = $urandom(); pz = $urandom();
         end
         send_word(op, px, py, pz, il, rc, rr, 1'b0, '0);
      end
   endtask

   // Directed rows at the reset camera: focal 1.0, center 0, full screen.
   plot_row_type plot_table [] = '{
      '{OP_READ,  0, 0, 0, 0, 7'd127, 6'd63, 1, '{1'b0, BLANK_CHAR, MAX_DEPTH}},
      '{OP_PLOT,  0, 0, 32'h0001_0000, 16'h1000, 0, 0, 1, '{1'b1, 8'h00, 32'h0}},
      '{OP_READ,  0, 0, 0, 0, 0, 0, 1, '{1'b0, 8'h40, 32'h0001_0000}},
      // repeat at the same depth: not nearer
      '{OP_PLOT,  0, 0, 32'h0001_0000, 16'h0800, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      // nearer, negative light
      '{OP_PLOT,  0, 0, 32'h0000_8000, 16'h8000, 0, 0, 1, '{1'b1, 8'h00, 32'h0}},
      '{OP_READ,  0, 0, 0, 0, 0, 0, 1, '{1'b0, 8'h2E, 32'h0000_8000}},
      // zero and negative depth
      '{OP_PLOT,  0, 0, 32'h0, 16'h0800, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_PLOT,  0, 0, 32'h8000_0000, 16'h0800, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_PLOT,  0, 0, 32'hFFFF_FFFF, 16'h0800, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      // off screen left, right, bottom
      '{OP_PLOT,  32'hFFFF_0000, 0, 32'h0001_0000, 0, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_PLOT,  32'h00C8_0000, 0, 32'h0001_0000, 0, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_PLOT,  0, 32'h0040_0000, 32'h0001_0000, 0, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      // far corner
      '{OP_PLOT,  32'h007F_0000, 32'h003F_0000, 32'h0001_0000, 16'h0800, 0, 0, 1,
        '{1'b1, 8'h00, 32'h0}},
      '{OP_READ,  0, 0, 0, 0, 7'd127, 6'd63, 1, '{1'b0, 8'h3D, 32'h0001_0000}},
      // half way rounds away from zero
      '{OP_PLOT,  32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 16'h0555, 0, 0, 0, '0},
      '{OP_PLOT,  32'hFFFF_8000, 0, 32'h0001_0000, 0, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_READ,  0, 0, 0, 0, 7'd1, 6'd1, 0, '0},
      // coordinate extremes
      '{OP_PLOT,  32'h7FFF_FFFF, 0, 32'h0001_0000, 0, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_PLOT,  32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, '0},
      '{OP_NONE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 7'd127, 6'd63,
        1, '{1'b0, 8'h00, 32'h0}},
      '{OP_CLEAR, 0, 0, 0, 0, 0, 0, 1, '{1'b0, 8'h00, 32'h0}},
      '{OP_READ,  0, 0, 0, 0, 0, 0, 1, '{1'b0, BLANK_CHAR, MAX_DEPTH}},
      // farthest legal depth, brightest light
      '{OP_PLOT,  0, 0, 32'h7FFF_FFFF, 16'h7FFF, 0, 0, 1, '{1'b1, 8'h00, 32'h0}},
      '{OP_READ,  0, 0, 0, 0, 0, 0, 1, '{1'b0, 8'h40, 32'h7FFF_FFFF}}
   };

   // Check each accepted result word; hold the ready off when asked and idle it at random.
   always @(posedge clock) begin
      pixel_result_type got, want;
      if (rsp_tvalid && rsp_tready) begin
         got.written     = rsp_tdata[0];
         got.pixel_char  = rsp_tdata[8:1];
         got.pixel_depth = rsp_tdata[40:9];
         if (owed_pixels.size() == 0) begin
            report("unexpected word", {23'd0, rsp_tdata[8:0]}, 32'h0);
         end else begin
            want = owed_pixels.pop_front();
            if (got.written !== want.written)
               report("written", {31'd0, got.written}, {31'd0, want.written});
            if (got.pixel_char !== want.pixel_char)
               report("pixel_char", {24'd0, got.pixel_char}, {24'd0, want.pixel_char});
            if (got.pixel_depth !== want.pixel_depth)
               report("pixel_depth", got.pixel_depth, want.pixel_depth);
         end
      end
      if (hold_seen != hold_count) begin
         hold_seen  <= hold_count;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(0, 99) >= 18);
      end
   end

   initial begin
      wipe_stores();
      cam_fx = 32'h0001_0000; cam_fy = 32'h0001_0000;
      cam_cx = 0; cam_cy = 0;
      act_cols = 8'd128; act_rows = 7'd64;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; the core is still sweeping after reset.
      foreach (plot_table[i])
         send_word(plot_table[i].op, plot_table[i].px, plot_table[i].py,
                   plot_table[i].pz, plot_table[i].illum, plot_table[i].rcol,
                   plot_table[i].rrow, plot_table[i].typed, plot_table[i].res);

      // Main camera: screen centered, x/z and y/z in -1..1 fill the screen.
      drain();
      write_camera(32'h0040_0000, 32'h0020_0000, 32'h0040_0000, 32'h0020_0000,
                   8'd128, 7'd64);
      random_words(600, -1, 150);

      // Single pixel screen: nearly every plot drops.
      drain();
      write_camera(32'h0040_0000, 32'h0020_0000, 32'h0040_0000, 32'h0020_0000,
                   8'd1, 7'd1);
      random_words(150, -1, -1);

      // Extreme registers: largest focal, most negative and positive center.
      drain();
      write_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                   8'd0, 7'd127);
      random_words(150, -1, -1);

      // Zero focal: every plot lands on one pixel, exercising depth tests.
      drain();
      write_camera(32'h0, 32'h0, 32'h0003_8000, 32'h000A_0000, 8'd255, 7'd127);
      random_words(200, -1, -1);

      // Small window, no idling on either side, one full pause.
      drain();
      write_camera(32'h0010_0000, 32'h0008_0000, 32'h0014_0000, 32'h000A_0000,
                   8'd40, 7'd20);
      calm = 1'b1;
      random_words(300, 150, -1);
      calm = 1'b0;

      // Back to the main camera.
      drain();
      write_camera(32'h0040_0000, 32'h0020_0000, 32'h0040_0000, 32'h0020_0000,
                   8'd128, 7'd64);
      random_words(300, -1, 100);

      drain();
      if (fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Bail out if the run hangs.
   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

endmodule
`default_nettype wire
